FILE: hw/rtl/percent_codec_assert.svh
// Assertion macros for the percent codec.
`ifndef PERCENT_CODEC_ASSERT_SVH
`define PERCENT_CODEC_ASSERT_SVH
`ifndef ASSERT_OFF
`define PC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("percent codec check failed");
`define PC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("percent codec check failed");
`else
`define PC_ASSERT(lbl, clk, rst, prop)
`define PC_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

FILE: hw/rtl/pcodec_pkg.sv
// Shared constants, types and helper functions of the percent codec.
package pcodec_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AT      = 8'h40;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 63;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ESC_PCT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FORM      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_LOW  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_HIGH = 3'd4;

  localparam logic [31:0] MASK_LOW_RESET  = 32'h5000_0007;
  localparam logic [62:0] MASK_HIGH_RESET = 63'h3800_0001_5000_0000;

  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_PCT   = 2'd1;
  localparam logic [1:0] HELD_DIGIT = 2'd2;

  typedef struct packed {
    logic        mode;
    logic        escape_percent;
    logic        form_plus_space;
    logic [31:0] mask_low;
    logic [62:0] mask_high;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } group_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + {4'h0, v};
    end
    return 8'h37 + {4'h0, v};
  endfunction

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: hw/rtl/pcodec_in_if.sv
// Input stream interface of the percent codec.
interface pcodec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

FILE: hw/rtl/pcodec_out_if.sv
// Result stream interface of the percent codec.
interface pcodec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_string;

  modport source (output valid, output out_byte, output last_of_string, input ready);
  modport sink (input valid, input out_byte, input last_of_string, output ready);
endinterface

FILE: hw/rtl/pcodec_convert.sv
// Per-byte encode and decode logic with the decoder's held-byte state.
`include "percent_codec_assert.svh"

module pcodec_convert (
  input  logic                clk,
  input  logic                rst,
  input  pcodec_pkg::cfg_t    cfg,
  input  logic                clear,
  input  logic                fire,
  input  pcodec_pkg::item_t   item,
  output pcodec_pkg::group_t  grp
);

  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;

  function automatic logic [7:0] dec_map(input logic form, input logic [7:0] x);
    return (form && x == pcodec_pkg::CH_PLUS) ? pcodec_pkg::CH_SPACE : x;
  endfunction

  logic             c_escape;
  logic             plain_hold;
  logic             mask_bit;
  logic [7:0]       c;
  pcodec_pkg::hex_t lo;
  pcodec_pkg::hex_t hi;

  assign c          = item.data_byte;
  assign lo         = pcodec_pkg::hex_value(c);
  assign hi         = pcodec_pkg::hex_value(held_digit);
  assign plain_hold = (c == pcodec_pkg::CH_PERCENT) && !item.end_of_string;
  assign mask_bit   = (c < pcodec_pkg::CH_AT) ? cfg.mask_low[c[4:0]] : cfg.mask_high[c[5:0]];
  assign c_escape   = ((c == pcodec_pkg::CH_PERCENT) && cfg.escape_percent) ||
                      (c < pcodec_pkg::CH_SPACE) || (c > pcodec_pkg::CH_TILDE) || mask_bit;

  always_comb begin
    grp             = '0;
    held_count_next = held_count;
    held_digit_next = held_digit;
    if (!cfg.mode) begin
      if (c_escape) begin
        grp.bytes[0] = pcodec_pkg::CH_PERCENT;
        grp.bytes[1] = pcodec_pkg::hex_char(c[7:4]);
        grp.bytes[2] = pcodec_pkg::hex_char(c[3:0]);
        grp.count    = 2'd3;
      end else begin
        grp.bytes[0] = (cfg.form_plus_space && c == pcodec_pkg::CH_SPACE) ?
                       pcodec_pkg::CH_PLUS : c;
        grp.count    = 2'd1;
      end
    end else begin
      unique case (held_count)
        pcodec_pkg::HELD_PCT: begin
          if (lo.ok && !item.end_of_string) begin
            held_digit_next = c;
            held_count_next = pcodec_pkg::HELD_DIGIT;
          end else begin
            grp.bytes[0] = pcodec_pkg::CH_PERCENT;
            if (plain_hold) begin
              grp.count       = 2'd1;
              held_count_next = pcodec_pkg::HELD_PCT;
            end else begin
              grp.bytes[1]    = dec_map(cfg.form_plus_space, c);
              grp.count       = 2'd2;
              held_count_next = pcodec_pkg::HELD_NONE;
            end
          end
        end
        pcodec_pkg::HELD_DIGIT: begin
          held_count_next = pcodec_pkg::HELD_NONE;
          held_digit_next = 8'h00;
          if (lo.ok && hi.ok) begin
            grp.bytes[0] = dec_map(cfg.form_plus_space, {hi.val, lo.val});
            grp.count    = 2'd1;
          end else begin
            grp.bytes[0] = pcodec_pkg::CH_PERCENT;
            grp.bytes[1] = dec_map(cfg.form_plus_space, held_digit);
            if (plain_hold) begin
              grp.count       = 2'd2;
              held_count_next = pcodec_pkg::HELD_PCT;
            end else begin
              grp.bytes[2] = dec_map(cfg.form_plus_space, c);
              grp.count    = 2'd3;
            end
          end
        end
        default: begin
          held_count_next = pcodec_pkg::HELD_NONE;
          if (plain_hold) begin
            held_count_next = pcodec_pkg::HELD_PCT;
          end else begin
            grp.bytes[0] = dec_map(cfg.form_plus_space, c);
            grp.count    = 2'd1;
          end
        end
      endcase
    end
    if (item.end_of_string) begin
      held_count_next = pcodec_pkg::HELD_NONE;
      held_digit_next = 8'h00;
      grp.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held_count <= pcodec_pkg::HELD_NONE;
      held_digit <= 8'h00;
    end else if (fire) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

  `PC_ASSERT(a_held_never_three, clk, rst, held_count != 2'd3)
  `PC_ASSERT_NEXT(a_end_clears_held, clk, rst, fire && !clear && item.end_of_string, held_count == pcodec_pkg::HELD_NONE)

endmodule

FILE: hw/rtl/percent_codec.sv
// Top level of the percent codec: configuration registers, converter and result queue.
//
//   channel  dir  beat contents
//   feed     in   data_byte, end_of_string
//   result   out  out_byte, last_of_string
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A byte is converted in the cycle it is accepted and its one to three result bytes are
// stored as one entry of a two-entry result queue, from which its bytes leave in order.
// Results leave one byte per cycle while the result side is ready: an escape yields three
// bytes, and a broken escape that the decoder passes through yields one to three.
// A beat the decoder holds produces no entry.
// The feed is ready whenever the queue has a free entry, so a stalled result does not stop
// it at once. Reset loads the register defaults, empties the queue and drops held bytes.
`include "percent_codec_assert.svh"

module percent_codec (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pcodec_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pcodec_pkg::CFG_DATA_W-1:0]    cfg_data,
  pcodec_in_if.sink                            feed,
  pcodec_out_if.source                         result
);

  pcodec_pkg::cfg_t   cfg;
  pcodec_pkg::item_t  item;
  pcodec_pkg::group_t grp;
  pcodec_pkg::group_t head;
  pcodec_pkg::group_t q_entries [2];

  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_count;
  logic [1:0] rd_idx;
  logic       accept;
  logic       push;
  logic       beat;
  logic       final_byte;
  logic       pop;
  logic       clear;

  assign clear = cfg_we && (cfg_index == pcodec_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= 1'b0;
      cfg.escape_percent  <= 1'b1;
      cfg.form_plus_space <= 1'b0;
      cfg.mask_low        <= pcodec_pkg::MASK_LOW_RESET;
      cfg.mask_high       <= pcodec_pkg::MASK_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcodec_pkg::REG_MODE:      cfg.mode            <= cfg_data[0];
        pcodec_pkg::REG_ESC_PCT:   cfg.escape_percent  <= cfg_data[0];
        pcodec_pkg::REG_FORM:      cfg.form_plus_space <= cfg_data[0];
        pcodec_pkg::REG_MASK_LOW:  cfg.mask_low        <= cfg_data[31:0];
        pcodec_pkg::REG_MASK_HIGH: cfg.mask_high       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign item.data_byte     = feed.data_byte;
  assign item.end_of_string = feed.end_of_string;

  assign feed.ready = (q_count != 2'd2);
  assign accept     = feed.valid && feed.ready;
  assign push       = accept && (grp.count != 2'd0);

  pcodec_convert u_convert (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .clear (clear),
    .fire  (accept),
    .item  (item),
    .grp   (grp)
  );

  assign head                  = q_entries[rd_ptr];
  assign final_byte            = (rd_idx == head.count - 2'd1);
  assign result.valid          = (q_count != 2'd0);
  assign result.out_byte       = head.bytes[rd_idx];
  assign result.last_of_string = head.last && final_byte;
  assign beat                  = result.valid && result.ready;
  assign pop                   = beat && final_byte;

  always_ff @(posedge clk) begin
    if (push) begin
      q_entries[wr_ptr] <= grp;
    end
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
      rd_idx  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
      if (beat) begin
        rd_idx <= pop ? 2'd0 : rd_idx + 2'd1;
      end
    end
  end

  `PC_ASSERT(a_queue_bound, clk, rst, q_count != 2'd3)
  `PC_ASSERT(a_head_not_empty, clk, rst, !result.valid || head.count != 2'd0)
  `PC_ASSERT(a_index_in_entry, clk, rst, !result.valid || rd_idx < head.count)
  `PC_ASSERT_NEXT(a_pop_frees_entry, clk, rst, pop && !push && q_count == 2'd2, feed.ready)

endmodule
